### hw/rtl/sh24_pkg.sv
// Shared types, constants and the SipHash round function for the stream hasher.
package sh24_pkg;

  localparam logic [63:0] SipC0  = 64'h736f6d6570736575;
  localparam logic [63:0] SipC1  = 64'h646f72616e646f6d;
  localparam logic [63:0] SipC2  = 64'h6c7967656e657261;
  localparam logic [63:0] SipC3  = 64'h7465646279746573;
  localparam logic [63:0] SipFin = 64'h00000000000000ff;
  localparam logic [3:0]  FullBytes = 4'd8;

  localparam logic KeyLowIdx  = 1'b0;
  localparam logic KeyHighIdx = 1'b1;

  typedef enum logic [1:0] {
    OP_BLOCK,
    OP_FINAL,
    OP_BLOCK_FINAL
  } op_kind_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COMP1,
    ST_COMP2,
    ST_FIN
  } core_state_e;

  typedef struct packed {
    logic        first;
    op_kind_e    kind;
    logic [63:0] m;
    logic [7:0]  len;
  } op_t;

  typedef struct packed {
    logic [63:0] k0;
    logic [63:0] k1;
  } key_t;

  typedef struct packed {
    logic [63:0] v0;
    logic [63:0] v1;
    logic [63:0] v2;
    logic [63:0] v3;
  } sip_state_t;

  function automatic logic [63:0] rotl(input logic [63:0] x, input int unsigned n);
    rotl = (x << n) | (x >> (64 - n));
  endfunction

  function automatic sip_state_t sip_round(input sip_state_t s);
    sip_state_t r;
    r = s;
    r.v0 = r.v0 + r.v1;
    r.v1 = rotl(r.v1, 13);
    r.v1 = r.v1 ^ r.v0;
    r.v0 = rotl(r.v0, 32);
    r.v2 = r.v2 + r.v3;
    r.v3 = rotl(r.v3, 16);
    r.v3 = r.v3 ^ r.v2;
    r.v0 = r.v0 + r.v3;
    r.v3 = rotl(r.v3, 21);
    r.v3 = r.v3 ^ r.v0;
    r.v2 = r.v2 + r.v1;
    r.v1 = rotl(r.v1, 17);
    r.v1 = r.v1 ^ r.v2;
    r.v2 = rotl(r.v2, 32);
    return r;
  endfunction

  function automatic sip_state_t sip_init(input key_t k);
    sip_state_t s;
    s.v0 = SipC0 ^ k.k0;
    s.v1 = SipC1 ^ k.k1;
    s.v2 = SipC2 ^ k.k0;
    s.v3 = SipC3 ^ k.k1;
    return s;
  endfunction

endpackage

### hw/rtl/sh24_front.sv
// Input stage: tracks message start and length, builds block operations.
module sh24_front import sh24_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  output logic        op_valid_o,
  input  logic        op_ready_i,
  output op_t         op_o
);

  logic       started_q, started_d;
  logic [7:0] len_q, len_d;
  logic [7:0] len_base;
  logic [7:0] len_new;
  logic [3:0] cnt_sat;
  logic [63:0] masked;
  logic       accept;

  assign in_ready_o = op_ready_i;
  assign op_valid_o = in_valid_i;
  assign accept     = in_valid_i & op_ready_i;

  assign len_base = started_q ? len_q : 8'd0;
  assign cnt_sat  = (byte_count_i > FullBytes) ? FullBytes : byte_count_i;
  assign len_new  = len_base + (last_i ? {4'd0, cnt_sat} : {4'd0, FullBytes});

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      masked[b*8 +: 8] = (4'(b) < cnt_sat) ? word_i[b*8 +: 8] : 8'd0;
    end
  end

  always_comb begin
    op_o.first = ~started_q;
    op_o.len   = len_new;
    if (!last_i) begin
      op_o.kind = OP_BLOCK;
      op_o.m    = word_i;
    end else if (cnt_sat == FullBytes) begin
      op_o.kind = OP_BLOCK_FINAL;
      op_o.m    = word_i;
    end else begin
      op_o.kind = OP_FINAL;
      op_o.m    = {len_new, masked[55:0]};
    end
  end

  always_comb begin
    started_d = started_q;
    len_d     = len_q;
    if (accept) begin
      started_d = ~last_i;
      len_d     = len_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      len_q     <= 8'd0;
    end else begin
      started_q <= started_d;
      len_q     <= len_d;
    end
  end

endmodule

### hw/rtl/sh24_fifo.sv
// Small operation queue between the input stage and the round engine.
module sh24_fifo import sh24_pkg::*; #(
  parameter int unsigned Depth = 4
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  op_t  push_op_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output op_t  pop_op_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  op_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic           push, pop;

  assign push_ready_o = (cnt_q != CntW'(Depth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_op_o     = mem_q[rd_ptr_q];
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_op_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### hw/rtl/sh24_core.sv
// Round engine: one SipRound per cycle unless the hash output stalls; compression, finalization, hash register.
module sh24_core import sh24_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  key_t        key_i,
  input  logic        op_valid_i,
  output logic        op_ready_o,
  input  op_t         op_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_o
);

  core_state_e state_q, state_d;
  sip_state_t  v_q, v_d;
  sip_state_t  rin, rout;
  logic [63:0] m_q, m_d;
  op_kind_e    kind_q, kind_d;
  logic [7:0]  len_q, len_d;
  logic [1:0]  fin_cnt_q, fin_cnt_d;
  logic        hash_valid_q, hash_valid_d;
  logic [63:0] hash_q, hash_d;
  logic        out_free;
  logic        pop;

  assign out_free    = ~hash_valid_q | out_ready_i;
  assign out_valid_o = hash_valid_q;
  assign hash_o      = hash_q;
  assign op_ready_o  = (state_q == ST_IDLE);
  assign pop         = op_valid_i & op_ready_o;
  assign rout        = sip_round(rin);

  always_comb begin
    rin = v_q;
    unique case (state_q)
      ST_IDLE: begin
        rin    = op_i.first ? sip_init(key_i) : v_q;
        rin.v3 = rin.v3 ^ op_i.m;
      end
      ST_COMP1: begin
        rin.v3 = v_q.v3 ^ m_q;
      end
      default: begin
        rin = v_q;
      end
    endcase
  end

  always_comb begin
    state_d      = state_q;
    v_d          = v_q;
    m_d          = m_q;
    kind_d       = kind_q;
    len_d        = len_q;
    fin_cnt_d    = fin_cnt_q;
    hash_d       = hash_q;
    hash_valid_d = hash_valid_q & ~out_ready_i;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          v_d     = rout;
          m_d     = op_i.m;
          kind_d  = op_i.kind;
          len_d   = op_i.len;
          state_d = ST_COMP2;
        end
      end
      ST_COMP1: begin
        v_d     = rout;
        state_d = ST_COMP2;
      end
      ST_COMP2: begin
        v_d    = rout;
        v_d.v0 = rout.v0 ^ m_q;
        unique case (kind_q)
          OP_BLOCK: begin
            state_d = ST_IDLE;
          end
          OP_BLOCK_FINAL: begin
            m_d     = {len_q, 56'd0};
            kind_d  = OP_FINAL;
            state_d = ST_COMP1;
          end
          default: begin
            v_d.v2    = rout.v2 ^ SipFin;
            fin_cnt_d = 2'd0;
            state_d   = ST_FIN;
          end
        endcase
      end
      ST_FIN: begin
        if (fin_cnt_q != 2'd3) begin
          v_d       = rout;
          fin_cnt_d = fin_cnt_q + 2'd1;
        end else if (out_free) begin
          v_d          = rout;
          hash_d       = rout.v0 ^ rout.v1 ^ rout.v2 ^ rout.v3;
          hash_valid_d = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    m_q    <= m_d;
    kind_q <= kind_d;
    len_q  <= len_d;
    hash_q <= hash_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      fin_cnt_q    <= 2'd0;
      hash_valid_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      fin_cnt_q    <= fin_cnt_d;
      hash_valid_q <= hash_valid_d;
    end
  end

`ifndef SYNTHESIS
  a_rise_after_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(hash_valid_q) |-> $past(state_q) == ST_FIN)
    else $error("hash valid without finalization");
  a_comp2_entry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COMP2) |-> ($past(state_q) == ST_IDLE || $past(state_q) == ST_COMP1))
    else $error("second compression round out of sequence");
  a_fin_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FIN && fin_cnt_q == 2'd3 && out_free) |=> state_q == ST_IDLE && hash_valid_q)
    else $error("finalization did not deliver a hash");
`endif

endmodule

### hw/rtl/siphash_2_4_stream.sv
// Keyed SipHash-2-4 stream hasher: 64-bit words in, one 64-bit hash per message.
// Throughput: the round engine does one SipRound per cycle unless the hash output stalls;
// a non-last word gets the compression rounds; a last word also gets the finalization rounds,
// after a length-block compression if it holds all eight bytes. Input words queue meanwhile.
// Reset: asynchronous, active low; clears control, length and keys, starts a new message.
module siphash_2_4_stream import sh24_pkg::*; #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [63:0] word_i,
  input  logic [3:0]  byte_count_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [63:0] hash_o
);

  key_t key_q, key_d;
  op_t  front_op, queue_op;
  logic front_valid, front_ready;
  logic queue_valid, queue_ready;

  always_comb begin
    key_d = key_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        KeyLowIdx: begin
          key_d.k0 = cfg_wdata_i;
        end
        KeyHighIdx: begin
          key_d.k1 = cfg_wdata_i;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else begin
      key_q <= key_d;
    end
  end

  sh24_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .word_i       (word_i),
    .byte_count_i (byte_count_i),
    .last_i       (last_i),
    .op_valid_o   (front_valid),
    .op_ready_i   (front_ready),
    .op_o         (front_op)
  );

  sh24_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .push_op_i    (front_op),
    .pop_valid_o  (queue_valid),
    .pop_ready_i  (queue_ready),
    .pop_op_o     (queue_op)
  );

  sh24_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_q),
    .op_valid_i  (queue_valid),
    .op_ready_o  (queue_ready),
    .op_i        (queue_op),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .hash_o      (hash_o)
  );

endmodule
